>>> hdl/assert_macros.svh
// Assertion macros shared by the statistics block.
// Included by the modules that check their own logic; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define WCQS_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) \
    else $error("wcqs assertion failed");
`define WCQS_NEVER(lbl, clk_s, rst_s, cond) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (!(cond))) \
    else $error("wcqs forbidden condition seen");
`else
`define WCQS_ASSERT(lbl, clk_s, rst_s, prop)
`define WCQS_NEVER(lbl, clk_s, rst_s, cond)
`endif
`endif

>>> hdl/wcqs_pkg.sv
// Package for the weighted coverage quartile statistics block.
// Holds field widths, defaults and register codes; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package wcqs_pkg;
  localparam int DEFAULT_MAX_NODES = 1024;
  localparam int LEN_W = 32;
  localparam int COV_W = 32;
  localparam int SEG_W = 8;
  localparam int CNT_OUT_W = 11;
  localparam int SUM_OUT_W = 42;
  localparam int APB_DW = 32;
  localparam int APB_AW = 1;
  localparam logic [APB_AW-1:0] ADDR_SEGMENTS = 1'b0;
  localparam logic [SEG_W-1:0] SEG_RESET = 8'd1;
endpackage
`default_nettype wire

>>> hdl/wcqs_front.sv
// Front end: accepts node items, writes coverage to the store, accumulates sums.
// Depends on wcqs_pkg; hands a packed job to the queue on the last node.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module wcqs_front #(
  parameter int MAX_NODES = wcqs_pkg::DEFAULT_MAX_NODES,
  parameter int CNT_W = $clog2(MAX_NODES + 1),
  parameter int IDX_W = $clog2(MAX_NODES),
  parameter int JOB_W = 5 * CNT_W + 5 * wcqs_pkg::LEN_W + wcqs_pkg::COV_W
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [wcqs_pkg::LEN_W-1:0]  node_length,
  input  wire logic [wcqs_pkg::COV_W-1:0]  coverage,
  input  wire logic                        is_positive,
  input  wire logic                        last_node,
  output logic                             busy,
  input  wire logic                        job_done,
  output logic                             wr_en,
  output logic [IDX_W-1:0]                 wr_addr,
  output logic [wcqs_pkg::COV_W-1:0]       wr_data,
  output logic                             push,
  output logic [JOB_W-1:0]                 job
);
  import wcqs_pkg::*;

  localparam int LSUM_W = LEN_W + CNT_W;
  localparam int WSUM_W = LEN_W + COV_W + CNT_W;
  localparam int PROD_W = LEN_W + COV_W;

  logic              busy_hold;
  logic [CNT_W-1:0]  load_cnt;
  logic              accept;
  logic              room;
  logic [PROD_W-1:0] prod_c;

  // Stage A registers.
  logic              a_vld;
  logic              a_ok;
  logic              a_last;
  logic              a_pos;
  logic [LEN_W-1:0]  a_len;
  logic [PROD_W-1:0] a_prod;
  logic [CNT_W-1:0]  a_n;

  // Accumulators.
  logic [CNT_W-1:0]  pcnt, pcnt_next;
  logic [LSUM_W-1:0] psum, psum_next;
  logic [LSUM_W-1:0] asum, asum_next;
  logic [WSUM_W-1:0] wsum, wsum_next;
  logic [LEN_W-1:0]  minl, minl_next;
  logic [LEN_W-1:0]  maxl, maxl_next;

  // Item acceptance and store write.
  assign accept  = start && !busy_hold;
  assign room    = (load_cnt < CNT_W'(MAX_NODES));
  assign wr_en   = accept && room;
  assign wr_addr = load_cnt[IDX_W-1:0];
  assign wr_data = coverage;
  assign busy    = busy_hold;
  assign prod_c  = PROD_W'(node_length) * PROD_W'(coverage);

  // Next accumulator values for the item in stage A.
  always_comb begin
    pcnt_next = pcnt;
    psum_next = psum;
    asum_next = asum;
    wsum_next = wsum;
    minl_next = minl;
    maxl_next = maxl;
    if (a_vld && a_ok) begin
      if (a_pos) begin
        pcnt_next = pcnt + CNT_W'(1);
        psum_next = psum + LSUM_W'(a_len);
      end
      asum_next = asum + LSUM_W'(a_len);
      wsum_next = wsum + WSUM_W'(a_prod);
      if (a_len < minl) minl_next = a_len;
      if (a_len > maxl) maxl_next = a_len;
    end
  end

  // Control and accumulator state.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy_hold <= 1'b0;
      load_cnt  <= '0;
      a_vld     <= 1'b0;
      push      <= 1'b0;
      pcnt      <= '0;
      psum      <= '0;
      asum      <= '0;
      wsum      <= '0;
      minl      <= '1;
      maxl      <= '0;
    end else begin
      a_vld <= accept;
      if (accept && last_node) begin
        busy_hold <= 1'b1;
      end else if (job_done) begin
        busy_hold <= 1'b0;
      end
      if (accept && last_node) begin
        load_cnt <= '0;
      end else if (accept && room) begin
        load_cnt <= load_cnt + CNT_W'(1);
      end
      push <= a_vld && a_last;
      if (a_vld && a_last) begin
        pcnt <= '0;
        psum <= '0;
        asum <= '0;
        wsum <= '0;
        minl <= '1;
        maxl <= '0;
      end else begin
        pcnt <= pcnt_next;
        psum <= psum_next;
        asum <= asum_next;
        wsum <= wsum_next;
        minl <= minl_next;
        maxl <= maxl_next;
      end
    end
  end

  // Item payload and job snapshot.
  always_ff @(posedge clk) begin
    if (accept) begin
      a_ok   <= room;
      a_last <= last_node;
      a_pos  <= is_positive;
      a_len  <= node_length;
      a_prod <= prod_c;
      a_n    <= load_cnt + CNT_W'(room);
    end
    if (a_vld && a_last) begin
      job <= {a_n, pcnt_next, psum_next, asum_next, wsum_next, minl_next, maxl_next};
    end
  end

  // A job is only handed over while the set is closed.
  `WCQS_ASSERT(a_push_while_busy, clk, rst, push |-> busy_hold)
endmodule
`default_nettype wire

>>> hdl/wcqs_queue.sv
// Two-entry job queue between the front end and the back end.
// Depends on assert_macros.svh only; payload width is a parameter.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module wcqs_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] din,
  input  wire logic         pop,
  output logic              empty,
  output logic [W-1:0]      dout
);
  logic [W-1:0] slots [2];
  logic         wptr;
  logic         rptr;
  logic [1:0]   fill;
  logic         full;

  assign empty = (fill == 2'd0);
  assign full  = (fill == 2'd2);
  assign dout  = slots[rptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= din;
  end

  `WCQS_NEVER(a_no_overflow, clk, rst, push && full && !pop)
  `WCQS_NEVER(a_no_underflow, clk, rst, pop && empty)
endmodule
`default_nettype wire

>>> hdl/wcqs_back.sv
// Back end: coverage store, shared serial divider and radix selection of quartiles.
// Depends on wcqs_pkg; takes jobs from the queue and drives the result ports.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module wcqs_back #(
  parameter int MAX_NODES = wcqs_pkg::DEFAULT_MAX_NODES,
  parameter int CNT_W = $clog2(MAX_NODES + 1),
  parameter int IDX_W = $clog2(MAX_NODES),
  parameter int JOB_W = 5 * CNT_W + 5 * wcqs_pkg::LEN_W + wcqs_pkg::COV_W
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          wr_en,
  input  wire logic [IDX_W-1:0]              wr_addr,
  input  wire logic [wcqs_pkg::COV_W-1:0]    wr_data,
  input  wire logic                          job_valid,
  input  wire logic [JOB_W-1:0]              job_in,
  output logic                               pop,
  input  wire logic [wcqs_pkg::SEG_W-1:0]    segments,
  output logic                               done,
  output logic [wcqs_pkg::CNT_OUT_W-1:0]     positive_count,
  output logic [wcqs_pkg::SUM_OUT_W-1:0]     positive_total_length,
  output logic [wcqs_pkg::LEN_W-1:0]         shortest_length,
  output logic [wcqs_pkg::LEN_W-1:0]         longest_length,
  output logic [wcqs_pkg::COV_W-1:0]         mean_coverage,
  output logic [wcqs_pkg::COV_W-1:0]         first_quartile,
  output logic [wcqs_pkg::COV_W-1:0]         median_coverage,
  output logic [wcqs_pkg::COV_W-1:0]         third_quartile,
  output logic [wcqs_pkg::SUM_OUT_W-1:0]     bases_per_segment
);
  import wcqs_pkg::*;

  localparam int LSUM_W = LEN_W + CNT_W;
  localparam int WSUM_W = LEN_W + COV_W + CNT_W;
  localparam int STEP_W = $clog2(WSUM_W);
  localparam int BIT_W  = $clog2(COV_W);
  localparam int SC_W   = CNT_W + 2;
  localparam int DV_W   = CNT_W + SEG_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_MEAN,
    S_DIV_BPS,
    S_SELECT,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [CNT_W-1:0]  n;
    logic [CNT_W-1:0]  pcnt;
    logic [LSUM_W-1:0] psum;
    logic [LSUM_W-1:0] asum;
    logic [WSUM_W-1:0] wsum;
    logic [LEN_W-1:0]  minl;
    logic [LEN_W-1:0]  maxl;
  } job_t;

  state_t            state;
  job_t              jin;
  logic [CNT_W-1:0]  n_q;
  logic [CNT_W-1:0]  pcnt_q;
  logic [LSUM_W-1:0] psum_q;
  logic [LEN_W-1:0]  minl_q;
  logic [LEN_W-1:0]  maxl_q;

  // Store.
  logic [COV_W-1:0]  store [MAX_NODES];
  logic [COV_W-1:0]  rd_data;
  logic [CNT_W-1:0]  issue;

  // Divider.
  logic [WSUM_W-1:0] dvd;
  logic [LSUM_W:0]   rem;
  logic [LSUM_W-1:0] dsr;
  logic [STEP_W-1:0] step;
  logic [LSUM_W:0]   rem_sh;
  logic              ge;
  logic [LSUM_W:0]   rem_nx;
  logic [WSUM_W-1:0] q_nx;
  logic              div_last;
  logic [DV_W-1:0]   bps_dsr;
  logic [COV_W-1:0]  mean_q;
  logic [SUM_OUT_W-1:0] bps_q;

  // Selection.
  logic [2:0]        j;
  logic [BIT_W-1:0]  bitpos;
  logic [COV_W-1:0]  mask;
  logic [COV_W-1:0]  prefix;
  logic [CNT_W-1:0]  below;
  logic [CNT_W-1:0]  cnt;
  logic              pend;
  logic [COV_W-1:0]  vals [6];
  logic              match;
  logic              sweep_end;
  logic [CNT_W-1:0]  total;
  logic [COV_W-1:0]  bitmask;
  logic              one_bit;
  logic [COV_W-1:0]  prefix_nx;
  logic [SC_W-1:0]   scaled;
  logic [CNT_W-1:0]  whole;
  logic [CNT_W-1:0]  nm1;
  logic [CNT_W-1:0]  rank;
  logic [1:0]        r1, r2, r3;
  logic [SC_W-1:0]   sc1, sc2, sc3;

  // Weighted blend of two neighbors at a quarter step, truncated.
  function automatic logic [COV_W-1:0] interp(input logic [COV_W-1:0] va,
                                              input logic [COV_W-1:0] vb,
                                              input logic [1:0] r);
    logic [COV_W+2:0] s;
    logic [2:0]       wa;
    wa = 3'd4 - {1'b0, r};
    s = (COV_W+3)'(va) * (COV_W+3)'(wa) + (COV_W+3)'(vb) * (COV_W+3)'(r);
    return s[COV_W+1:2];
  endfunction

  assign jin = job_t'(job_in);
  assign pop = (state == S_IDLE) && job_valid;

  // Coverage store: one write port from the front end, one registered read.
  always_ff @(posedge clk) begin
    if (wr_en) store[wr_addr] <= wr_data;
    rd_data <= store[issue[IDX_W-1:0]];
  end

  // One restoring division step.
  assign rem_sh   = {rem[LSUM_W-1:0], dvd[WSUM_W-1]};
  assign ge       = (rem_sh >= {1'b0, dsr});
  assign rem_nx   = ge ? (rem_sh - {1'b0, dsr}) : rem_sh;
  assign q_nx     = {dvd[WSUM_W-2:0], ge};
  assign div_last = (step == STEP_W'(WSUM_W - 1));
  assign bps_dsr  = DV_W'(pcnt_q) * DV_W'(segments);

  // Rank wanted for selection slot j: the lower or upper neighbor of k*N/4.
  assign scaled = SC_W'({1'b0, j[2:1]} + 3'd1) * SC_W'(n_q);
  assign whole  = scaled[SC_W-1:2];
  assign nm1    = n_q - CNT_W'(1);
  always_comb begin
    if (whole >= nm1) begin
      rank = nm1;
    end else if (j[0]) begin
      rank = whole + CNT_W'(1);
    end else begin
      rank = whole;
    end
  end

  // Bitwise selection: count entries that agree above bitpos and hold 0 there.
  assign match     = (((rd_data ^ prefix) & mask) == '0) && !rd_data[bitpos];
  assign sweep_end = (issue == n_q) && !pend;
  assign total     = below + cnt;
  assign bitmask   = COV_W'(1) << bitpos;
  assign one_bit   = (rank >= total);
  assign prefix_nx = one_bit ? (prefix | bitmask) : prefix;

  // Fractions of the three quartile positions.
  assign sc1 = SC_W'(n_q);
  assign sc2 = SC_W'(n_q) << 1;
  assign sc3 = sc1 + sc2;
  assign r1  = sc1[1:0];
  assign r2  = sc2[1:0];
  assign r3  = sc3[1:0];

  // Sequencer for division and selection, with registered results.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            n_q    <= jin.n;
            pcnt_q <= jin.pcnt;
            psum_q <= jin.psum;
            minl_q <= jin.minl;
            maxl_q <= jin.maxl;
            dvd    <= jin.wsum;
            dsr    <= jin.asum;
            rem    <= '0;
            step   <= '0;
            state  <= S_DIV_MEAN;
          end
        end
        S_DIV_MEAN: begin
          if (dsr == '0 || div_last) begin
            mean_q <= (dsr == '0) ? '0 : q_nx[COV_W-1:0];
            dvd    <= WSUM_W'(psum_q);
            dsr    <= LSUM_W'(bps_dsr);
            rem    <= '0;
            step   <= '0;
            state  <= S_DIV_BPS;
          end else begin
            dvd  <= q_nx;
            rem  <= rem_nx;
            step <= step + STEP_W'(1);
          end
        end
        S_DIV_BPS: begin
          if (dsr == '0 || div_last) begin
            bps_q  <= (dsr == '0) ? '0 : q_nx[SUM_OUT_W-1:0];
            j      <= '0;
            bitpos <= BIT_W'(COV_W - 1);
            mask   <= '0;
            prefix <= '0;
            below  <= '0;
            cnt    <= '0;
            issue  <= '0;
            pend   <= 1'b0;
            state  <= (n_q == '0) ? S_FINISH : S_SELECT;
          end else begin
            dvd  <= q_nx;
            rem  <= rem_nx;
            step <= step + STEP_W'(1);
          end
        end
        S_SELECT: begin
          pend <= (issue < n_q);
          if (issue < n_q) issue <= issue + CNT_W'(1);
          if (pend && match) cnt <= cnt + CNT_W'(1);
          if (sweep_end) begin
            cnt   <= '0;
            issue <= '0;
            if (bitpos == '0) begin
              vals[j] <= prefix_nx;
              j       <= j + 3'd1;
              bitpos  <= BIT_W'(COV_W - 1);
              mask    <= '0;
              prefix  <= '0;
              below   <= '0;
              if (j == 3'd5) state <= S_FINISH;
            end else begin
              if (one_bit) below <= total;
              prefix <= prefix_nx;
              mask   <= mask | bitmask;
              bitpos <= bitpos - BIT_W'(1);
            end
          end
        end
        S_FINISH: begin
          positive_count        <= CNT_OUT_W'(pcnt_q);
          positive_total_length <= SUM_OUT_W'(psum_q);
          shortest_length       <= (n_q == '0) ? '0 : minl_q;
          longest_length        <= (n_q == '0) ? '0 : maxl_q;
          mean_coverage         <= mean_q;
          bases_per_segment     <= bps_q;
          first_quartile        <= (n_q == '0) ? '0 : interp(vals[0], vals[1], r1);
          median_coverage       <= (n_q == '0) ? '0 : interp(vals[2], vals[3], r2);
          third_quartile        <= (n_q == '0) ? '0 : interp(vals[4], vals[5], r3);
          done                  <= 1'b1;
          state                 <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Selection sweeps never run over an empty set.
  `WCQS_ASSERT(a_select_nonempty, clk, rst, (state == S_SELECT) |-> (n_q != '0))
  // A result strobe is always seen with the sequencer back in idle.
  `WCQS_ASSERT(a_done_idle, clk, rst, done |-> (state == S_IDLE))
endmodule
`default_nettype wire

>>> hdl/weighted_coverage_quartile_stats.sv
// Channel   | Signals                                         | Handshake
// ----------+-------------------------------------------------+----------------------
// node in   | node_length, coverage, is_positive, last_node   | start && !busy
// result    | positive_count .. bases_per_segment             | done, one cycle
// config    | psel, penable, pwrite, paddr, pwdata, prdata    | APB, pready tied high
//
// Nodes load at one item per clock while busy is low; a set closes with its last node.
// After the last node the back end runs two divisions of 64 + CNT_W steps each
// (a zero divisor skips the steps and gives a zero result), then six selection
// searches of 32 sweeps over the N stored coverages, each sweep reading them through
// the single read port of the coverage store. busy stays high from the last node
// through the result strobe; rst is synchronous and clears the sequencer state,
// queue pointers and front-end control and sums. Results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none
module weighted_coverage_quartile_stats #(
  parameter int MAX_NODES = wcqs_pkg::DEFAULT_MAX_NODES
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [wcqs_pkg::LEN_W-1:0]    node_length,
  input  wire logic [wcqs_pkg::COV_W-1:0]    coverage,
  input  wire logic                          is_positive,
  input  wire logic                          last_node,
  output logic                               done,
  output logic [wcqs_pkg::CNT_OUT_W-1:0]     positive_count,
  output logic [wcqs_pkg::SUM_OUT_W-1:0]     positive_total_length,
  output logic [wcqs_pkg::LEN_W-1:0]         shortest_length,
  output logic [wcqs_pkg::LEN_W-1:0]         longest_length,
  output logic [wcqs_pkg::COV_W-1:0]         mean_coverage,
  output logic [wcqs_pkg::COV_W-1:0]         first_quartile,
  output logic [wcqs_pkg::COV_W-1:0]         median_coverage,
  output logic [wcqs_pkg::COV_W-1:0]         third_quartile,
  output logic [wcqs_pkg::SUM_OUT_W-1:0]     bases_per_segment,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [wcqs_pkg::APB_AW-1:0]   paddr,
  input  wire logic [wcqs_pkg::APB_DW-1:0]   pwdata,
  output logic [wcqs_pkg::APB_DW-1:0]        prdata,
  output logic                               pready
);
  import wcqs_pkg::*;

  localparam int CNT_W = $clog2(MAX_NODES + 1);
  localparam int IDX_W = $clog2(MAX_NODES);
  localparam int JOB_W = 5 * CNT_W + 5 * LEN_W + COV_W;

  logic [SEG_W-1:0] segments;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [COV_W-1:0] wr_data;
  logic             push;
  logic [JOB_W-1:0] job_front;
  logic [JOB_W-1:0] job_back;
  logic             q_empty;
  logic             pop;

  // Configuration register.
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_SEGMENTS) ? APB_DW'(segments) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      segments <= SEG_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_SEGMENTS)) begin
      segments <= pwdata[SEG_W-1:0];
    end
  end

  // Front end: loading and accumulation.
  wcqs_front #(
    .MAX_NODES(MAX_NODES), .CNT_W(CNT_W), .IDX_W(IDX_W), .JOB_W(JOB_W)
  ) u_front (
    .clk, .rst, .start, .node_length, .coverage, .is_positive, .last_node,
    .busy, .job_done(done), .wr_en, .wr_addr, .wr_data, .push, .job(job_front)
  );

  // Job queue.
  wcqs_queue #(.W(JOB_W)) u_queue (
    .clk, .rst, .push, .din(job_front), .pop, .empty(q_empty), .dout(job_back)
  );

  // Back end: division, selection and results.
  wcqs_back #(
    .MAX_NODES(MAX_NODES), .CNT_W(CNT_W), .IDX_W(IDX_W), .JOB_W(JOB_W)
  ) u_back (
    .clk, .rst, .wr_en, .wr_addr, .wr_data, .job_valid(!q_empty),
    .job_in(job_back), .pop, .segments, .done, .positive_count,
    .positive_total_length, .shortest_length, .longest_length, .mean_coverage,
    .first_quartile, .median_coverage, .third_quartile, .bases_per_segment
  );
endmodule
`default_nettype wire
